FILE: sv/dnsp_pkg.sv
package dnsp_pkg;

  localparam int unsigned MaxMessageBytes = 1500;
  localparam int unsigned HdrBytes = 12;
  localparam logic [7:0] PtrMark = 8'hC0;

  typedef enum logic [3:0] {
    PH_HDR   = 4'd0,
    PH_QNAME = 4'd1,
    PH_QFIX  = 4'd2,
    PH_AFIX  = 4'd3,
    PH_NAME1 = 4'd4,
    PH_NAMEZ = 4'd5,
    PH_NAMEP = 4'd6,
    PH_RFIX  = 4'd7,
    PH_DATA  = 4'd8,
    PH_DONE  = 4'd9
  } phase_t;

  typedef enum logic [3:0] {
    K_HEADER   = 4'd0,
    K_QUESTION = 4'd1,
    K_ANSWER   = 4'd2,
    K_AUTH     = 4'd3,
    K_OPT      = 4'd4,
    K_ADDL     = 4'd5,
    K_NAME     = 4'd6,
    K_DATA     = 4'd7,
    K_END      = 4'd8
  } kind_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRAILING = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  localparam logic [15:0] TYPE_A    = 16'd1;
  localparam logic [15:0] TYPE_SOA  = 16'd6;
  localparam logic [15:0] TYPE_TXT  = 16'd16;
  localparam logic [15:0] TYPE_AAAA = 16'd28;
  localparam logic [15:0] TYPE_OPT  = 16'd41;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] field_a;
    logic [15:0] field_b;
    logic [31:0] field_c;
    logic [15:0] field_d;
    logic [7:0]  byte_value;
    logic [1:0]  status;
    logic [15:0] parsed_length;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } item_t;

endpackage

FILE: sv/dnsp_if.sv
interface dnsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;
  modport source (output valid, data_byte, end_of_packet, input ready);
  modport sink (input valid, data_byte, end_of_packet, output ready);
endinterface

interface dnsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [15:0] field_a;
  logic [15:0] field_b;
  logic [31:0] field_c;
  logic [15:0] field_d;
  logic [7:0]  byte_value;
  logic [1:0]  status;
  logic [15:0] parsed_length;
  logic        last_result;
  modport source (output valid, kind, field_a, field_b, field_c, field_d, byte_value,
                  status, parsed_length, last_result, input ready);
  modport sink (input valid, kind, field_a, field_b, field_c, field_d, byte_value,
                status, parsed_length, last_result, output ready);
endinterface

FILE: sv/dnsp_core.sv
// Parse state: takes one byte and gives up to two results (record, end).
module dnsp_core #(
  parameter int unsigned MAX_MESSAGE_BYTES = dnsp_pkg::MaxMessageBytes
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  dnsp_pkg::item_t   item,
  output logic              res0_vld,
  output dnsp_pkg::result_t res0,
  output logic              res1_vld,
  output dnsp_pkg::result_t res1
);
  import dnsp_pkg::*;

  phase_t       phase_r, phase_nxt;
  logic [3:0]   bif_r, bif_nxt;
  logic [15:0]  pos_r, pos_nxt;
  logic [15:0]  cons_r, cons_nxt;
  logic [15:0]  qd_r, qd_nxt, an_r, an_nxt, ns_r, ns_nxt, ar_r, ar_nxt;
  logic [119:0] asm_r;
  logic [127:0] asm_new;
  logic [15:0]  rem_r, rem_nxt;
  logic         fail_r, fail_nxt;

  logic [7:0]   b;
  logic [63:0]  lo, hi;
  logic         parse;
  logic [15:0]  dlen, rtype;

  assign b = item.data_byte;
  assign asm_new = {asm_r, b};
  assign lo = asm_new[63:0];
  assign hi = asm_new[127:64];
  assign dlen = lo[15:0];
  assign rtype = hi[15:0];

  // per-byte parse step
  always_comb begin
    phase_t sec;
    logic   over;
    phase_nxt = phase_r;
    bif_nxt   = bif_r;
    pos_nxt   = pos_r;
    cons_nxt  = cons_r;
    qd_nxt = qd_r; an_nxt = an_r; ns_nxt = ns_r; ar_nxt = ar_r;
    rem_nxt   = rem_r;
    fail_nxt  = fail_r;
    res0_vld  = 1'b0;
    res0      = '0;
    over = (32'(pos_r) >= MAX_MESSAGE_BYTES);
    if (over) fail_nxt = 1'b1;
    else pos_nxt = pos_r + 16'd1;
    parse = !fail_nxt && (phase_r != PH_DONE);
    sec = PH_DONE;
    if (parse) begin
      cons_nxt = cons_r + 16'd1;
      unique case (phase_r)
        PH_HDR: begin
          if (bif_r < 4'd11) begin
            bif_nxt = bif_r + 4'd1;
          end else begin
            res0_vld = 1'b1;
            res0.kind = K_HEADER;
            res0.field_a = hi[31:16];
            res0.field_b = hi[15:0];
            qd_nxt = lo[63:48]; an_nxt = lo[47:32];
            ns_nxt = lo[31:16]; ar_nxt = lo[15:0];
            bif_nxt = '0; rem_nxt = '0;
          end
        end
        PH_QNAME: begin
          if (rem_r == '0 && b == 8'd0) begin
            phase_nxt = PH_QFIX;
            bif_nxt = '0;
          end else begin
            rem_nxt = (rem_r == '0) ? {8'd0, b} : rem_r - 16'd1;
            res0_vld = 1'b1;
            res0.kind = K_NAME;
            res0.byte_value = b;
          end
        end
        PH_QFIX: begin
          if (bif_r < 4'd3) begin
            bif_nxt = bif_r + 4'd1;
          end else begin
            res0_vld = 1'b1;
            res0.kind = K_QUESTION;
            res0.field_a = lo[31:16];
            res0.field_b = lo[15:0];
            qd_nxt = qd_r - 16'd1;
            bif_nxt = '0; rem_nxt = '0;
          end
        end
        PH_AFIX: begin
          if (bif_r < 4'd11) begin
            bif_nxt = bif_r + 4'd1;
          end else begin
            res0_vld = 1'b1;
            res0.kind = K_ANSWER;
            res0.field_a = hi[15:0];
            res0.field_b = lo[63:48];
            res0.field_c = lo[47:16];
            res0.field_d = dlen;
            an_nxt = an_r - 16'd1;
            bif_nxt = '0;
            rem_nxt = dlen;
          end
        end
        PH_NAME1: begin
          bif_nxt = '0;
          if (b == 8'd0) phase_nxt = PH_RFIX;
          else if (b < PtrMark) phase_nxt = PH_NAMEZ;
          else phase_nxt = PH_NAMEP;
        end
        PH_NAMEZ: begin
          if (b == 8'd0) begin
            phase_nxt = PH_RFIX;
            bif_nxt = '0;
          end
        end
        PH_NAMEP: begin
          phase_nxt = PH_RFIX;
          bif_nxt = '0;
        end
        PH_RFIX: begin
          if (bif_r < 4'd9) begin
            bif_nxt = bif_r + 4'd1;
          end else begin
            res0.field_a = rtype;
            res0.field_b = lo[63:48];
            res0.field_c = lo[47:16];
            res0.field_d = dlen;
            bif_nxt = '0;
            rem_nxt = dlen;
            if (ns_r != '0) begin
              if (rtype != TYPE_SOA) begin
                fail_nxt = 1'b1;
              end else begin
                res0_vld = 1'b1;
                res0.kind = K_AUTH;
                ns_nxt = ns_r - 16'd1;
              end
            end else if (rtype == TYPE_OPT) begin
              res0_vld = 1'b1;
              res0.kind = K_OPT;
              ar_nxt = ar_r - 16'd1;
            end else if (rtype == TYPE_A || rtype == TYPE_AAAA || rtype == TYPE_TXT) begin
              res0_vld = 1'b1;
              res0.kind = K_ADDL;
              ar_nxt = ar_r - 16'd1;
            end else begin
              fail_nxt = 1'b1;
            end
            if (fail_nxt) begin
              bif_nxt = bif_r;
              rem_nxt = rem_r;
              res0 = '0;
            end
          end
        end
        PH_DATA: begin
          res0_vld = 1'b1;
          res0.kind = K_DATA;
          res0.byte_value = b;
          rem_nxt = (rem_r != '0) ? rem_r - 16'd1 : rem_r;
        end
        default: fail_nxt = 1'b1;
      endcase
      // section sequencing after a finished header, question or record
      if (qd_nxt != '0) sec = PH_QNAME;
      else if (an_nxt != '0) sec = PH_AFIX;
      else if (ns_nxt != '0 || ar_nxt != '0) sec = PH_NAME1;
      else sec = PH_DONE;
      if (res0_vld && (res0.kind == K_HEADER || res0.kind == K_QUESTION)) begin
        phase_nxt = sec;
      end else if (res0_vld && res0.kind != K_NAME) begin
        if (rem_nxt != '0) phase_nxt = PH_DATA;
        else begin
          phase_nxt = sec;
          bif_nxt = '0;
        end
      end
    end
  end

  // end-of-message result
  always_comb begin
    res1_vld = item.end_of_packet;
    res1 = '0;
    res1.kind = K_END;
    res1.last_result = 1'b1;
    res1.status = ST_ERROR;
    if (!fail_nxt && phase_nxt == PH_DONE && pos_nxt > 16'(HdrBytes)) begin
      res1.status = (pos_nxt > cons_nxt) ? ST_TRAILING : ST_OK;
      res1.parsed_length = cons_nxt;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.end_of_packet)) begin
      phase_r <= PH_HDR;
      bif_r <= '0; pos_r <= '0; cons_r <= '0;
      qd_r <= '0; an_r <= '0; ns_r <= '0; ar_r <= '0;
      asm_r <= '0; rem_r <= '0; fail_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bif_r <= bif_nxt; pos_r <= pos_nxt; cons_r <= cons_nxt;
      qd_r <= qd_nxt; an_r <= an_nxt; ns_r <= ns_nxt; ar_r <= ar_nxt;
      if (parse) asm_r <= asm_new[119:0];
      rem_r <= rem_nxt; fail_r <= fail_nxt;
    end
  end

  // a failure stays set until the message's end byte
  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (fail_r && step && !item.end_of_packet) |=> fail_r) else $error("fail lost");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) <= MAX_MESSAGE_BYTES) else $error("position past limit");
  a_cons_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cons_r <= pos_r) else $error("consumed exceeds position");
endmodule

FILE: sv/dns_message_parser.sv
// DNS message parser.
// in:  one message byte per request, end_of_packet on the last byte.
// out: results (header, question, records, name/data bytes, end), several
//      per message; the last byte gives up to two results (record + end).
// Results are registered: each result is written into the output queue and shown from its head.
// Throughput: one byte per cycle while results are taken each cycle. A byte
// that yields two results holds the input while both wait in the two-entry
// output buffer, which drains one result per cycle.
// The parse state sits in one stage; the output is a two-entry queue, so
// in_ready stays high while a waiting result is taken in the same cycle,
// leaving room for the two results a byte can produce.
// Reset (rst_n low, synchronous) empties the queue and returns the parser
// to the header phase; the parser (not the queue) also returns there after each end result.
// Receiver stall: results wait in the queue; once it cannot take two more,
// in_ready drops until out_ready frees space.
module dns_message_parser #(
  parameter int unsigned MAX_MESSAGE_BYTES = dnsp_pkg::MaxMessageBytes
) (
  input logic clk,
  input logic rst_n,
  dnsp_in_if.sink    in_ch,
  dnsp_out_if.source out_ch
);
  import dnsp_pkg::*;

  logic    step, r0v, r1v;
  item_t   item;
  result_t r0, r1;
  result_t q_r [2];
  result_t q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] base_cnt;
  logic pop;

  assign item.data_byte = in_ch.data_byte;
  assign item.end_of_packet = in_ch.end_of_packet;
  assign in_ch.ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);
  assign step = in_ch.valid && in_ch.ready;
  assign pop = out_ch.valid && out_ch.ready;

  dnsp_core #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_core (
    .clk, .rst_n, .step, .item,
    .res0_vld(r0v), .res0(r0), .res1_vld(r1v), .res1(r1)
  );

  // two-entry result queue, head at slot 0
  always_comb begin
    cnt_nxt = cnt_r - {1'b0, pop} + (step ? 2'({1'b0, r0v} + {1'b0, r1v}) : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  // queue contents after pop and push
  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    base_cnt = cnt_r - {1'b0, pop};
    if (pop) q_nxt[0] = q_r[1];
    if (step) begin
      if (r0v && r1v) begin
        q_nxt[0] = r0;
        q_nxt[1] = r1;
      end else if (r0v || r1v) begin
        if (base_cnt == 2'd0) q_nxt[0] = r0v ? r0 : r1;
        else q_nxt[1] = r0v ? r0 : r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.kind = q_r[0].kind;
  assign out_ch.field_a = q_r[0].field_a;
  assign out_ch.field_b = q_r[0].field_b;
  assign out_ch.field_c = q_r[0].field_c;
  assign out_ch.field_d = q_r[0].field_d;
  assign out_ch.byte_value = q_r[0].byte_value;
  assign out_ch.status = q_r[0].status;
  assign out_ch.parsed_length = q_r[0].parsed_length;
  assign out_ch.last_result = q_r[0].last_result;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue overflow");
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_ch.ready) else $error("accept while full");
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_result) |-> (out_ch.kind == K_END))
    else $error("last without end");
endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import dnsp_pkg::*;

  logic clk;
  logic rst_n;

  dnsp_in_if  in_ch ();
  dnsp_out_if out_ch ();

  dns_message_parser DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // clock, 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  item_t   pending_bytes[$];
  result_t expected_results[$];

  // parser state mirror
  phase_t      p_phase;
  logic [3:0]  p_idx;
  logic [15:0] p_pos;
  logic [15:0] p_used;
  logic [15:0] p_qd, p_an, p_ns, p_ar;
  logic [63:0] p_lo, p_hi;
  logic [15:0] p_left;
  logic        p_bad;

  int errors;
  int n_results;
  int n_requests;
  int n_messages;
  int cycle_count;
  bit stim_done;

  task automatic report(input string what, input result_t got, input result_t exp);
    errors++;
    $display("MISMATCH %s: got %h expected %h", what, got, exp);
  endtask

  function automatic void parser_clear();
    p_phase = PH_HDR;
    p_idx = '0;
    p_pos = '0;
    p_used = '0;
    p_qd = '0;
    p_an = '0;
    p_ns = '0;
    p_ar = '0;
    p_lo = '0;
    p_hi = '0;
    p_left = '0;
    p_bad = 1'b0;
  endfunction

  function automatic void push_result(input kind_t k, input logic [15:0] a,
                                      input logic [15:0] b, input logic [31:0] c,
                                      input logic [15:0] d, input logic [7:0] bv,
                                      input logic [1:0] st, input logic [15:0] pl,
                                      input logic lr);
    result_t r;
    r.kind = k;
    r.field_a = a;
    r.field_b = b;
    r.field_c = c;
    r.field_d = d;
    r.byte_value = bv;
    r.status = st;
    r.parsed_length = pl;
    r.last_result = lr;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void pick_section();
    p_idx = '0;
    p_left = '0;
    if (p_qd != 0) p_phase = PH_QNAME;
    else if (p_an != 0) p_phase = PH_AFIX;
    else if (p_ns != 0 || p_ar != 0) p_phase = PH_NAME1;
    else p_phase = PH_DONE;
  endfunction

  function automatic void after_fixed_part(input logic [15:0] dlen);
    if (dlen != 0) begin
      p_phase = PH_DATA;
      p_left = dlen;
    end else begin
      pick_section();
    end
  endfunction

  function automatic void parse_one(input logic [7:0] b);
    logic [15:0] rtype;
    logic [15:0] dlen;
    p_hi = {p_hi[55:0], p_lo[63:56]};
    p_lo = {p_lo[55:0], b};
    rtype = p_hi[15:0];
    dlen = p_lo[15:0];
    case (p_phase)
      PH_HDR: begin
        if (p_idx < 11) begin
          p_idx++;
        end else begin
          push_result(K_HEADER, p_hi[31:16], p_hi[15:0], 0, 0, 0, 0, 0, 0);
          p_qd = p_lo[63:48];
          p_an = p_lo[47:32];
          p_ns = p_lo[31:16];
          p_ar = p_lo[15:0];
          pick_section();
        end
      end
      PH_QNAME: begin
        if (p_left == 0 && b == 0) begin
          p_phase = PH_QFIX;
          p_idx = '0;
        end else begin
          if (p_left == 0) p_left = b;
          else p_left--;
          push_result(K_NAME, 0, 0, 0, 0, b, 0, 0, 0);
        end
      end
      PH_QFIX: begin
        if (p_idx < 3) begin
          p_idx++;
        end else begin
          push_result(K_QUESTION, p_lo[31:16], p_lo[15:0], 0, 0, 0, 0, 0, 0);
          p_qd--;
          pick_section();
        end
      end
      PH_AFIX: begin
        if (p_idx < 11) begin
          p_idx++;
        end else begin
          push_result(K_ANSWER, p_hi[15:0], p_lo[63:48], p_lo[47:16], dlen, 0, 0, 0, 0);
          p_an--;
          after_fixed_part(dlen);
        end
      end
      PH_NAME1: begin
        p_idx = '0;
        if (b == 0) p_phase = PH_RFIX;
        else if (b < PtrMark) p_phase = PH_NAMEZ;
        else p_phase = PH_NAMEP;
      end
      PH_NAMEZ: begin
        if (b == 0) begin
          p_phase = PH_RFIX;
          p_idx = '0;
        end
      end
      PH_NAMEP: begin
        p_phase = PH_RFIX;
        p_idx = '0;
      end
      PH_RFIX: begin
        if (p_idx < 9) begin
          p_idx++;
        end else if (p_ns != 0) begin
          if (rtype != TYPE_SOA) begin
            p_bad = 1'b1;
          end else begin
            push_result(K_AUTH, rtype, p_lo[63:48], p_lo[47:16], dlen, 0, 0, 0, 0);
            p_ns--;
            after_fixed_part(dlen);
          end
        end else if (rtype == TYPE_OPT || rtype == TYPE_A || rtype == TYPE_AAAA ||
                     rtype == TYPE_TXT) begin
          push_result(rtype == TYPE_OPT ? K_OPT : K_ADDL, rtype, p_lo[63:48],
                      p_lo[47:16], dlen, 0, 0, 0, 0);
          p_ar--;
          after_fixed_part(dlen);
        end else begin
          p_bad = 1'b1;
        end
      end
      PH_DATA: begin
        push_result(K_DATA, 0, 0, 0, 0, b, 0, 0, 0);
        if (p_left != 0) p_left--;
        if (p_left == 0) pick_section();
      end
      default: p_bad = 1'b1;
    endcase
  endfunction

  // expected results for one accepted request
  function automatic void predict_byte(input item_t it);
    logic [1:0]  st;
    logic [15:0] pl;
    if (p_pos >= MaxMessageBytes) p_bad = 1'b1;
    else p_pos++;
    if (!p_bad && p_phase != PH_DONE) begin
      p_used++;
      parse_one(it.data_byte);
    end
    if (it.end_of_packet) begin
      st = ST_ERROR;
      pl = '0;
      if (!p_bad && p_phase == PH_DONE && p_pos > HdrBytes) begin
        st = (p_pos > p_used) ? ST_TRAILING : ST_OK;
        pl = p_used;
      end
      push_result(K_END, 0, 0, 0, 0, 0, st, pl, 1'b1);
      parser_clear();
    end
  endfunction

  // message building
  byte msg[$];

  function automatic void put8(input int v);
    msg.insert(msg.size(), v[7:0]);
  endfunction

  function automatic void put16(input int v);
    put8(v[15:8]);
    put8(v[7:0]);
  endfunction

  function automatic void put_rand(input int n);
    repeat (n) put8($urandom_range(0, 255));
  endfunction

  function automatic void put_header(input int qd, input int an, input int ns, input int ar);
    put16($urandom);
    put16($urandom);
    put16(qd);
    put16(an);
    put16(ns);
    put16(ar);
  endfunction

  function automatic void put_qname();
    int labels;
    int len;
    labels = $urandom_range(0, 3);
    repeat (labels) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(192, 196) : $urandom_range(1, 5);
      put8(len);
      put_rand(len);
    end
    put8(0);
  endfunction

  function automatic void put_skip_name();
    int len;
    case ($urandom_range(0, 2))
      0: put8(0);
      1: begin
        put8($urandom_range(192, 255));
        put8($urandom);
      end
      default: begin
        len = $urandom_range(1, 6);
        put8(len);
        repeat (len) put8($urandom_range(1, 255));
        put8(0);
      end
    endcase
  endfunction

  function automatic void put_rr(input int rtype);
    int dlen;
    dlen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    put16(rtype);
    put16($urandom);
    put16($urandom);
    put16($urandom);
    put16(dlen);
    put_rand(dlen);
  endfunction

  function automatic int addl_type();
    case ($urandom_range(0, 3))
      0: return TYPE_OPT;
      1: return TYPE_A;
      2: return TYPE_AAAA;
      default: return TYPE_TXT;
    endcase
  endfunction

  function automatic void queue_msg();
    item_t it;
    for (int i = 0; i < msg.size(); i++) begin
      it.data_byte = msg[i];
      it.end_of_packet = (i == msg.size() - 1);
      pending_bytes.insert(pending_bytes.size(), it);
    end
    msg.delete();
    n_messages++;
  endfunction

  // well-formed message with random content, possibly damaged
  function automatic void build_message();
    int qd, an, ns, ar, flaw, cut;
    qd = $urandom_range(0, 2);
    an = $urandom_range(0, 2);
    ns = $urandom_range(0, 1);
    ar = $urandom_range(0, 2);
    flaw = $urandom_range(0, 9);
    put_header(qd, an, ns, ar);
    repeat (qd) begin
      put_qname();
      put16($urandom);
      put16($urandom);
    end
    repeat (an) begin
      put8($urandom_range(192, 255));
      put8($urandom);
      put_rr($urandom);
    end
    repeat (ns) begin
      put_skip_name();
      put_rr(flaw == 0 ? $urandom_range(7, 65535) : TYPE_SOA);
    end
    repeat (ar) begin
      put_skip_name();
      put_rr(flaw == 1 ? $urandom_range(2, 15) : addl_type());
    end
    if (flaw == 2) put_rand($urandom_range(1, 4));
    if (flaw == 3 && msg.size() > 1) begin
      cut = $urandom_range(1, msg.size() - 1);
      while (msg.size() > cut) void'(msg.pop_back());
    end
    if (flaw == 4) begin
      msg.delete();
      put_rand($urandom_range(1, 30));
    end
  endfunction

  // stimulus
  initial begin
    errors = 0;
    n_messages = 0;
    stim_done = 1'b0;
    parser_clear();

    // directed: empty message, random header, short message, trailing bytes
    put_header(0, 0, 0, 0);
    queue_msg();
    put_rand(12);
    queue_msg();
    put_rand(1);
    queue_msg();
    put_header(0, 0, 0, 0);
    put_rand(3);
    queue_msg();
    // every record kind, pointer names, 0xC0 question length
    put8(8'hFF);
    put8(8'hFF);
    put8(8'hFF);
    put8(8'hFF);
    put16(1);
    put16(1);
    put16(1);
    put16(2);
    put8(8'hC0);
    repeat (192) put8(8'hFF);
    put8(0);
    put16(16'hFFFF);
    put16(16'hFFFF);
    put8(8'hC0);
    put8(8'h0C);
    put_rr(16'hFFFF);
    put8(0);
    put_rr(TYPE_SOA);
    put8(3);
    put_rand(3);
    put8(0);
    put_rr(TYPE_OPT);
    put8(8'hC1);
    put8(0);
    put_rr(TYPE_AAAA);
    queue_msg();
    // bad authority, bad additional
    put_header(0, 0, 1, 0);
    put8(0);
    put_rr(TYPE_A);
    queue_msg();
    put_header(0, 0, 0, 1);
    put8(0);
    put_rr(TYPE_SOA);
    queue_msg();

    // random messages up to the byte budget
    while (pending_bytes.size() < 950) begin
      build_message();
      if (msg.size() == 0) put_rand(1);
      queue_msg();
    end
    stim_done = 1'b1;
  end

  // reset
  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: bursts and gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.end_of_packet <= 1'b0;
      burst_left <= $urandom_range(1, 40);
      gap_left <= 0;
      n_requests <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(pending_bytes.pop_front());
        n_requests <= n_requests + 1;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // holding current request
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= pending_bytes[0].data_byte;
        in_ch.end_of_packet <= pending_bytes[0].end_of_packet;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern and result checking
  logic [7:0] stall_lfsr;
  result_t got, exp;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_lfsr <= 8'h5A;
      n_results <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.kind;
        got.field_a = out_ch.field_a;
        got.field_b = out_ch.field_b;
        got.field_c = out_ch.field_c;
        got.field_d = out_ch.field_d;
        got.byte_value = out_ch.byte_value;
        got.status = out_ch.status;
        got.parsed_length = out_ch.parsed_length;
        got.last_result = out_ch.last_result;
        n_results <= n_results + 1;
        if (expected_results.size() == 0) begin
          report("unexpected result", got, got);
        end else begin
          exp = expected_results.pop_front();
          if (got.kind != exp.kind) report("kind", got, exp);
          if (got.field_a != exp.field_a) report("field_a", got, exp);
          if (got.field_b != exp.field_b) report("field_b", got, exp);
          if (got.field_c != exp.field_c) report("field_c", got, exp);
          if (got.field_d != exp.field_d) report("field_d", got, exp);
          if (got.byte_value != exp.byte_value) report("byte_value", got, exp);
          if (got.status != exp.status) report("status", got, exp);
          if (got.parsed_length != exp.parsed_length) report("parsed_length", got, exp);
          if (got.last_result != exp.last_result) report("last_result", got, exp);
        end
      end
      stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^
                     stall_lfsr[3]};
      // long stall-free stretches when the top bits line up
      out_ch.ready <= (stall_lfsr[7:6] == 2'b11) ? 1'b1 : (stall_lfsr[2:0] != 3'b000);
    end
  end

  // end of run and watchdog
  initial begin
    cycle_count = 0;
    wait (rst_n === 1'b1);
    while (!(stim_done && pending_bytes.size() == 0 && !in_ch.valid &&
             expected_results.size() == 0) && cycle_count < 200000) begin
      @(posedge clk);
      cycle_count++;
    end
    if (cycle_count >= 200000) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      $display("%0d bytes in %0d messages, %0d results checked, %0d mismatches",
               n_requests, n_messages, n_results, errors);
      if (errors == 0 && expected_results.size() == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
      $finish;
    end
  end

endmodule
